// File: rtl/phc_pkg.sv
// shared types and constants for the horizontal half-plane polygon clipper
package phc_pkg;

  localparam int CW = 32;
  localparam int XW = CW + 1;
  localparam int CNTW = $clog2(XW + 1);
  localparam int NSLOT = 5;

  // word slots of one vertex, in emission order
  localparam int SLOT_S1 = 0;
  localparam int SLOT_X1 = 1;
  localparam int SLOT_S2 = 2;
  localparam int SLOT_X2 = 3;
  localparam int SLOT_END = 4;

  typedef struct packed {
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic                 is_last_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 has_vertex;
    logic                 ends_polygon;
  } vtx_out_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] level;
  } xu_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
  } xu_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_PICK, ST_CALC, ST_EMIT} seq_state_t;
  typedef enum logic [1:0] {XS_IDLE, XS_MUL, XS_DIV, XS_FIN} xu_state_t;

endpackage

// File: rtl/phc_xunit.sv
// crossing unit: one multiply, then a serial restoring divide, then saturating add
module phc_xunit (
  input  logic             clk,
  input  logic             rst,
  input  phc_pkg::xu_req_t req,
  output phc_pkg::xu_rsp_t rsp
);

  localparam logic signed [phc_pkg::CW+1:0] SMAX =
    (phc_pkg::CW+2)'({1'b0, {(phc_pkg::CW-1){1'b1}}});
  localparam logic signed [phc_pkg::CW+1:0] SMIN =
    -(phc_pkg::CW+2)'({1'b1, {(phc_pkg::CW-1){1'b0}}});

  phc_pkg::xu_state_t st, st_next;

  logic [phc_pkg::XW-1:0]   ma, mb, md;
  logic                     neg;
  logic signed [phc_pkg::CW-1:0] xs_r;
  logic [2*phc_pkg::XW-1:0] pw;
  logic [phc_pkg::CNTW-1:0] cnt;
  logic signed [phc_pkg::CW-1:0] res;
  logic                     done;

  logic signed [phc_pkg::XW-1:0] da, db, dd;
  logic [phc_pkg::XW:0]          trial;
  logic [phc_pkg::XW-1:0]        hi_new;
  logic                          qbit;
  logic signed [phc_pkg::CW+1:0] qs, sum, sat;

  always_comb begin
    da = phc_pkg::XW'(req.level) - phc_pkg::XW'(req.ys);
    db = phc_pkg::XW'(req.xe) - phc_pkg::XW'(req.xs);
    dd = phc_pkg::XW'(req.ye) - phc_pkg::XW'(req.ys);
  end

  // one divide step on the subtractor
  always_comb begin
    trial  = {pw[2*phc_pkg::XW-1:phc_pkg::XW], pw[phc_pkg::XW-1]} - {1'b0, md};
    qbit   = !trial[phc_pkg::XW];
    hi_new = qbit ? trial[phc_pkg::XW-1:0] : pw[2*phc_pkg::XW-2:phc_pkg::XW-1];
  end

  always_comb begin
    qs  = $signed({1'b0, pw[phc_pkg::XW-1:0]});
    sum = neg ? ($signed({{2{xs_r[phc_pkg::CW-1]}}, xs_r}) - qs)
              : ($signed({{2{xs_r[phc_pkg::CW-1]}}, xs_r}) + qs);
    if (sum > SMAX) begin
      sat = SMAX;
    end else if (sum < SMIN) begin
      sat = SMIN;
    end else begin
      sat = sum;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      phc_pkg::XS_IDLE: if (req.start) st_next = phc_pkg::XS_MUL;
      phc_pkg::XS_MUL:  st_next = phc_pkg::XS_DIV;
      phc_pkg::XS_DIV:  if (cnt == phc_pkg::CNTW'(phc_pkg::XW - 1)) st_next = phc_pkg::XS_FIN;
      phc_pkg::XS_FIN:  st_next = phc_pkg::XS_IDLE;
      default:          st_next = phc_pkg::XS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= phc_pkg::XS_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      st   <= st_next;
      done <= (st == phc_pkg::XS_FIN);
      if (st == phc_pkg::XS_MUL) begin
        cnt <= '0;
      end else if (st == phc_pkg::XS_DIV) begin
        cnt <= cnt + phc_pkg::CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == phc_pkg::XS_IDLE && req.start) begin
      ma   <= da[phc_pkg::XW-1] ? phc_pkg::XW'(-da) : phc_pkg::XW'(da);
      mb   <= db[phc_pkg::XW-1] ? phc_pkg::XW'(-db) : phc_pkg::XW'(db);
      md   <= dd[phc_pkg::XW-1] ? phc_pkg::XW'(-dd) : phc_pkg::XW'(dd);
      neg  <= da[phc_pkg::XW-1] ^ db[phc_pkg::XW-1] ^ dd[phc_pkg::XW-1];
      xs_r <= req.xs;
    end
    if (st == phc_pkg::XS_MUL) begin
      pw <= ma * mb;
    end else if (st == phc_pkg::XS_DIV) begin
      pw <= {hi_new, pw[phc_pkg::XW-2:0], qbit};
    end
    if (st == phc_pkg::XS_FIN) begin
      res <= phc_pkg::CW'(sat);
    end
  end

  assign rsp.done = done;
  assign rsp.x    = res;

endmodule

// File: rtl/polygon_horizontal_halfplane_clip.sv
// top level of the horizontal half-plane polygon clipper
// Clips a polygon, one vertex word at a time, against y >= clip_level
// (Sutherland-Hodgman, one edge). Each vertex is accepted while idle and the
// block then stays busy until all its words have gone into the output
// register: up to three vertex words, or one empty end marker. A crossing
// point waits on the serial restoring divider in the crossing unit, which
// takes one quotient bit per cycle after a single registered multiply; any
// stall on the output side also holds the block.
// clip_level is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module polygon_horizontal_halfplane_clip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  phc_pkg::vtx_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output phc_pkg::vtx_out_t            out_data,
  input  logic                         cfg_we,
  input  logic signed [phc_pkg::CW-1:0] cfg_data
);

  phc_pkg::seq_state_t st, st_next;

  // cut level and polygon state
  logic signed [phc_pkg::CW-1:0] clip_level;
  logic signed [phc_pkg::CW-1:0] first_x, first_y;
  logic signed [phc_pkg::CW-1:0] prev_x, prev_y;   // after accept: current vertex
  logic signed [phc_pkg::CW-1:0] e1_x, e1_y;       // start of edge prev -> current
  logic                          in_polygon;
  logic                          last_r;
  logic [phc_pkg::NSLOT-1:0]     mask;              // words still owed for this vertex

  logic                          acc;
  logic                          out_free;
  logic                          load;
  logic [phc_pkg::NSLOT-1:0]     low;
  logic                          is_cross;
  logic                          in_e, in_p, in_f;
  logic signed [phc_pkg::CW-1:0] fx, fy;
  logic [phc_pkg::NSLOT-1:0]     mask_new;
  phc_pkg::vtx_out_t             word;
  phc_pkg::xu_req_t              req;
  phc_pkg::xu_rsp_t              rsp;

  phc_xunit u_xunit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // lowest owed slot goes next
  assign low      = mask & (~mask + phc_pkg::NSLOT'(1));
  assign is_cross = low[phc_pkg::SLOT_X1] | low[phc_pkg::SLOT_X2];
  assign out_free = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  // classify the new vertex against the level on acceptance
  always_comb begin
    fx   = in_polygon ? first_x : in_data.in_x;
    fy   = in_polygon ? first_y : in_data.in_y;
    in_e = in_data.in_y >= clip_level;
    in_p = prev_y >= clip_level;
    in_f = fy >= clip_level;
    mask_new = '0;
    mask_new[phc_pkg::SLOT_S1] = in_polygon && in_p;
    mask_new[phc_pkg::SLOT_X1] = in_polygon && (in_p != in_e);
    mask_new[phc_pkg::SLOT_S2] = in_data.is_last_vertex && in_e;
    mask_new[phc_pkg::SLOT_X2] = in_data.is_last_vertex && (in_e != in_f);
    mask_new[phc_pkg::SLOT_END] = in_data.is_last_vertex &&
      (mask_new[phc_pkg::SLOT_X2:phc_pkg::SLOT_S1] == '0);
  end

  // crossing edge: prev -> current, or the closing edge current -> first
  always_comb begin
    req.level = clip_level;
    if (low[phc_pkg::SLOT_X1]) begin
      req.xs = e1_x;
      req.ys = e1_y;
      req.xe = prev_x;
      req.ye = prev_y;
    end else begin
      req.xs = prev_x;
      req.ys = prev_y;
      req.xe = first_x;
      req.ye = first_y;
    end
  end

  // word for the selected slot; ends flag when nothing else is owed
  always_comb begin
    word.has_vertex   = 1'b1;
    word.ends_polygon = last_r && ((mask & ~low) == '0);
    if (low[phc_pkg::SLOT_S1]) begin
      word.out_x = e1_x;
      word.out_y = e1_y;
    end else if (low[phc_pkg::SLOT_S2]) begin
      word.out_x = prev_x;
      word.out_y = prev_y;
    end else if (is_cross) begin
      word.out_x = rsp.x;
      word.out_y = clip_level;
    end else begin
      word.out_x      = '0;
      word.out_y      = '0;
      word.has_vertex = 1'b0;
    end
  end

  // sequencer next state
  always_comb begin
    st_next = st;
    unique case (st)
      phc_pkg::ST_IDLE: if (acc) st_next = phc_pkg::ST_PICK;
      phc_pkg::ST_PICK: begin
        if (mask == '0) begin
          st_next = phc_pkg::ST_IDLE;
        end else if (is_cross) begin
          st_next = phc_pkg::ST_CALC;
        end else begin
          st_next = phc_pkg::ST_EMIT;
        end
      end
      phc_pkg::ST_CALC: if (rsp.done) st_next = phc_pkg::ST_EMIT;
      phc_pkg::ST_EMIT: if (out_free) st_next = phc_pkg::ST_PICK;
      default:          st_next = phc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (st == phc_pkg::ST_IDLE);
    req.start = (st == phc_pkg::ST_PICK) && is_cross;
    load      = (st == phc_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= phc_pkg::ST_IDLE;
      clip_level <= '0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      in_polygon <= 1'b0;
      last_r     <= 1'b0;
      mask       <= '0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_we) begin
        clip_level <= cfg_data;
      end
      if (acc) begin
        first_x    <= fx;
        first_y    <= fy;
        prev_x     <= in_data.in_x;
        prev_y     <= in_data.in_y;
        in_polygon <= !in_data.is_last_vertex;
        last_r     <= in_data.is_last_vertex;
        mask       <= mask_new;
      end else if (load) begin
        mask <= mask & ~low;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      e1_x <= prev_x;
      e1_y <= prev_y;
    end
    if (load) begin
      out_data <= word;
    end
  end

  a_calc_to_emit: assert property (@(posedge clk) disable iff (rst)
    (st == phc_pkg::ST_CALC && rsp.done) |=> st == phc_pkg::ST_EMIT)
    else $error("crossing result not taken to emit");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> st == phc_pkg::ST_CALC)
    else $error("crossing unit finished outside calc");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (load && word.ends_polygon) |=> mask == '0)
    else $error("end word sent with words still owed");

endmodule
